// File: src/rlle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlle_pkg
// Shared types and constants of the run-length / literal-group encoder.
// ----------------------------------------------------------------------------
package rlle_pkg;

  localparam int unsigned SYM_W     = 8;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned MAX_OUT   = 8;   // most bytes one input beat can cause
  localparam int unsigned OUT_IDX_W = 3;   // index into the bytes of one bundle
  localparam int unsigned OUT_CNT_W = 4;   // holds 0..MAX_OUT

  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QPTR_W    = 2;
  localparam int unsigned QCNT_W    = 3;

  localparam logic [CNT_W-1:0] RUN_LIMIT  = 4'd9;
  localparam logic [SYM_W-1:0] MARK_ONE   = 8'h31;
  localparam logic [SYM_W-1:0] DIGIT_ZERO = 8'h30;
  localparam logic [SYM_W-1:0] NEWLINE    = 8'h0a;

  // all bytes caused by one input beat, in order
  typedef struct packed {
    logic [MAX_OUT-1:0][SYM_W-1:0] bytes;
    logic [OUT_CNT_W-1:0]          cnt;
  } rlle_bundle_t;

endpackage : rlle_pkg
`default_nettype wire

// File: src/run_length_literal_encoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// run_length_literal_encoder_core
// Byte stream encoder: runs become count digit plus byte, single bytes are
// gathered into literal groups framed by '1' markers.
//
// in_*  : one byte of a line per beat; in_tuser says the byte is present,
//         in_tlast ends the line (flush, close group, newline).
// out_* : encoded bytes, one per beat; out_tlast marks the last byte caused
//         by one input beat.
// An input beat is taken every cycle while the 4-entry bundle queue has
// room. A beat causes 0 to 8 output bytes; the first passes through the
// queue into the output register, the rest follow one per cycle while
// out_tready is high. Sustained rate is one output byte per cycle, set by
// the back end's single output register; zero-byte beats push nothing.
// Synchronous reset clears the pending chunk, the open-group flag, the queue
// and the output valid flag. When out_tready is low the output register
// holds its byte, the queue fills, and in_tready drops once it is full.
// ----------------------------------------------------------------------------
module run_length_literal_encoder_core
  import rlle_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [7:0]       in_tdata,   // [7:0] symbol
  input  wire logic             in_tuser,   // symbol_valid
  input  wire logic             in_tlast,   // end_of_line
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [7:0]            out_tdata,  // [7:0] out_byte
  output logic                  out_tlast   // last_of_run
);

  rlle_bundle_t push_data, head_data;
  logic         push, q_full, head_valid, pop;

  rlle_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (push),
    .q_wdata   (push_data)
  );

  rlle_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wdata  (push_data),
    .full   (q_full),
    .pop    (pop),
    .rvalid (head_valid),
    .rdata  (head_data)
  );

  rlle_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (head_valid),
    .q_rdata    (head_data),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule : run_length_literal_encoder_core
`default_nettype wire

// File: src/rlle_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlle_front
// Takes input beats, tracks the pending chunk and literal group, and builds
// the bundle of output bytes each beat causes.
// ----------------------------------------------------------------------------
module rlle_front
  import rlle_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [SYM_W-1:0]   in_tdata,   // [7:0] symbol
  input  wire logic               in_tuser,   // symbol_valid
  input  wire logic               in_tlast,   // end_of_line
  input  wire logic               q_full,
  output logic                    q_push,
  output rlle_bundle_t            q_wdata
);

  logic [SYM_W-1:0] held_symbol_r, held_symbol_nxt;
  logic [CNT_W-1:0] held_count_r, held_count_nxt;
  logic             literal_open_r, literal_open_nxt;
  logic [MAX_OUT-1:0][SYM_W-1:0] b;
  logic [OUT_CNT_W-1:0]          n;
  logic             accept;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    held_count_nxt   = held_count_r;
    held_symbol_nxt  = held_symbol_r;
    literal_open_nxt = literal_open_r;
    b = '0;
    n = '0;

    if (in_tuser) begin
      if (held_count_nxt != '0 && in_tdata == held_symbol_nxt &&
          held_count_nxt < RUN_LIMIT) begin
        held_count_nxt = held_count_nxt + CNT_W'(1);
      end else begin
        // flush the pending chunk
        if (held_count_nxt == CNT_W'(1)) begin
          if (!literal_open_nxt) begin
            b[n[OUT_IDX_W-1:0]] = MARK_ONE;
            n = n + OUT_CNT_W'(1);
            literal_open_nxt = 1'b1;
          end
          b[n[OUT_IDX_W-1:0]] = held_symbol_nxt;
          n = n + OUT_CNT_W'(1);
          if (held_symbol_nxt == MARK_ONE) begin
            b[n[OUT_IDX_W-1:0]] = held_symbol_nxt;
            n = n + OUT_CNT_W'(1);
          end
        end else if (held_count_nxt != '0) begin
          if (literal_open_nxt) begin
            b[n[OUT_IDX_W-1:0]] = MARK_ONE;
            n = n + OUT_CNT_W'(1);
            literal_open_nxt = 1'b0;
          end
          b[n[OUT_IDX_W-1:0]] = DIGIT_ZERO + SYM_W'(held_count_nxt);
          n = n + OUT_CNT_W'(1);
          b[n[OUT_IDX_W-1:0]] = held_symbol_nxt;
          n = n + OUT_CNT_W'(1);
        end
        held_symbol_nxt = in_tdata;
        held_count_nxt  = CNT_W'(1);
      end
    end

    if (in_tlast) begin
      if (held_count_nxt == CNT_W'(1)) begin
        if (!literal_open_nxt) begin
          b[n[OUT_IDX_W-1:0]] = MARK_ONE;
          n = n + OUT_CNT_W'(1);
          literal_open_nxt = 1'b1;
        end
        b[n[OUT_IDX_W-1:0]] = held_symbol_nxt;
        n = n + OUT_CNT_W'(1);
        if (held_symbol_nxt == MARK_ONE) begin
          b[n[OUT_IDX_W-1:0]] = held_symbol_nxt;
          n = n + OUT_CNT_W'(1);
        end
      end else if (held_count_nxt != '0) begin
        if (literal_open_nxt) begin
          b[n[OUT_IDX_W-1:0]] = MARK_ONE;
          n = n + OUT_CNT_W'(1);
          literal_open_nxt = 1'b0;
        end
        b[n[OUT_IDX_W-1:0]] = DIGIT_ZERO + SYM_W'(held_count_nxt);
        n = n + OUT_CNT_W'(1);
        b[n[OUT_IDX_W-1:0]] = held_symbol_nxt;
        n = n + OUT_CNT_W'(1);
      end
      held_count_nxt = '0;
      // close the group, then newline
      if (literal_open_nxt) begin
        b[n[OUT_IDX_W-1:0]] = MARK_ONE;
        n = n + OUT_CNT_W'(1);
        literal_open_nxt = 1'b0;
      end
      b[n[OUT_IDX_W-1:0]] = NEWLINE;
      n = n + OUT_CNT_W'(1);
      held_symbol_nxt = '0;
    end
  end

  assign q_push        = accept && (n != '0);
  assign q_wdata.bytes = b;
  assign q_wdata.cnt   = n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_symbol_r  <= '0;
      held_count_r   <= '0;
      literal_open_r <= 1'b0;
    end else if (accept) begin
      held_symbol_r  <= held_symbol_nxt;
      held_count_r   <= held_count_nxt;
      literal_open_r <= literal_open_nxt;
    end
  end

endmodule : rlle_front
`default_nettype wire

// File: src/rlle_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlle_fifo
// Short queue of byte bundles between the front and the back.
// ----------------------------------------------------------------------------
module rlle_fifo
  import rlle_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire rlle_bundle_t  wdata,
  output logic               full,
  input  wire logic          pop,
  output logic               rvalid,
  output rlle_bundle_t       rdata
);

  rlle_bundle_t      mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push, do_pop;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign rvalid  = (cnt_r != '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && rvalid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

endmodule : rlle_fifo
`default_nettype wire

// File: src/rlle_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlle_back
// Walks the bytes of the head bundle, one beat per cycle while out_tready
// is high, into an output register; marks the last byte of each bundle.
// ----------------------------------------------------------------------------
module rlle_back
  import rlle_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire rlle_bundle_t      q_rdata,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [SYM_W-1:0]       out_tdata,  // [7:0] out_byte
  output logic                   out_tlast   // last_of_run
);

  logic                 out_valid_r;
  logic [SYM_W-1:0]     out_data_r;
  logic                 out_last_r;
  logic [OUT_IDX_W-1:0] idx_r, idx_nxt;
  logic                 load, is_last;

  assign load    = !out_valid_r || out_tready;
  assign is_last = ({1'b0, idx_r} + OUT_CNT_W'(1)) == q_rdata.cnt;
  assign q_pop   = load && q_valid && is_last;
  assign idx_nxt = is_last ? '0 : idx_r + OUT_IDX_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (load) begin
      out_valid_r <= q_valid;
      if (q_valid) begin
        idx_r <= idx_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_valid) begin
      out_data_r <= q_rdata.bytes[idx_r];
      out_last_r <= is_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule : rlle_back
`default_nettype wire
